[hw/rtl/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    P_HDR0 = 3'd0,  // first header byte: FIN, RSV, opcode
    P_HDR1 = 3'd1,  // second header byte: MASK, length code
    P_EXT  = 3'd2,  // extended length bytes
    P_KEY  = 3'd3,  // masking key bytes
    P_PAY  = 3'd4   // payload bytes
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    RK_HEADER  = 2'd0,
    RK_PAYLOAD = 2'd1,
    RK_LEN_ERR = 2'd2
  } kind_t;

  // One result transfer
  typedef struct packed {
    kind_t       kind;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [31:0] length;
    logic [7:0]  payload;
    logic        last;
  } result_t;

  // Length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Byte counts of the extended length and the masking key
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_WRAP  = 3'd0;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  // Register map (byte addresses)
  localparam logic [2:0]  ADDR_MAX_LEN  = 3'd0;
  localparam logic [31:0] MAX_LEN_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] LEN_SATURATED = 32'hFFFF_FFFF;

endpackage

[hw/rtl/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket (RFC 6455) frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock on data_byte while in_ready is high,
// and decodes the frame header (FIN, RSV, opcode, MASK, 7-bit, 16-bit or 64-bit
// length, masking key). When the header is complete it sends one header result,
// then one result per payload byte, unmasked with the key byte at index mod 4;
// last_of_frame marks the final result of a frame. A length above the limit in
// max_payload_length (register at address 0, reset 0xFFFFFFFF) sends one error
// result and then drops every byte until reset. Each byte is parsed by the phase
// logic between the parser state and the result register, so the block accepts
// one byte every clock while in_ready is high, and the result register holds its
// result. A two-entry output buffer (result register plus skid register) keeps
// input flowing while a result waits; in_ready drops only while both entries
// are occupied.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic        fin_flag,
  output logic [2:0]  rsv_bits,
  output logic [3:0]  frame_opcode,
  output logic        masked_flag,
  output logic [31:0] frame_length,
  output logic [7:0]  payload_byte,
  output logic        last_of_frame,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsdf_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [2:0]  fbc, fbc_next;
  logic [63:0] acc, acc_next;
  logic [31:0] remaining, remaining_next;
  logic [7:0]  mask_key [4];
  logic [1:0]  key_index, key_index_next;
  logic        held_fin, held_fin_next;
  logic [2:0]  held_rsv, held_rsv_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic        held_mask, held_mask_next;
  logic [6:0]  length_code, length_code_next;
  logic        error_latched, error_latched_next;
  logic [31:0] max_len;

  // Per-byte control
  logic        fire_in;
  logic        step;
  logic        len_done;
  logic        too_long;
  logic        hdr_done;
  logic        key_wr;
  logic [1:0]  key_wr_idx;
  logic        res_valid;
  result_t     res;

  // Output buffer
  logic        skid_valid;
  result_t     skid;
  result_t     out_reg;

  assign in_ready = !skid_valid;
  assign fire_in  = in_valid && in_ready;
  assign step     = fire_in && !error_latched;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_LEN) ? max_len : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_LEN) begin
      max_len <= pwdata;
    end
  end

  // Byte datapath: field capture, length assembly and result build
  always_comb begin
    fbc_next           = fbc;
    acc_next           = acc;
    remaining_next     = remaining;
    key_index_next     = key_index;
    held_fin_next      = held_fin;
    held_rsv_next      = held_rsv;
    held_opcode_next   = held_opcode;
    held_mask_next     = held_mask;
    length_code_next   = length_code;
    error_latched_next = error_latched;
    len_done           = 1'b0;
    too_long           = 1'b0;
    hdr_done           = 1'b0;
    key_wr             = 1'b0;
    key_wr_idx         = fbc[1:0];
    res_valid          = 1'b0;
    res                = '0;

    if (step) begin
      case (phase)
        P_HDR1: begin
          held_mask_next   = data_byte[7];
          length_code_next = data_byte[6:0];
          fbc_next         = 3'd0;
          if (data_byte[6:0] < LEN_CODE_16) begin
            acc_next = {57'd0, data_byte[6:0]};
            len_done = 1'b1;
          end else begin
            acc_next = 64'd0;
          end
        end
        P_EXT: begin
          acc_next = {acc[55:0], data_byte};
          fbc_next = fbc + 3'd1;
          len_done = (length_code == LEN_CODE_16 && fbc_next == EXT16_BYTES) ||
                     (length_code == LEN_CODE_64 && fbc_next == EXT64_WRAP);
        end
        P_KEY: begin
          key_wr   = 1'b1;
          fbc_next = fbc + 3'd1;
          if (fbc_next >= KEY_BYTES) begin
            fbc_next = 3'd0;
            hdr_done = 1'b1;
          end
        end
        P_PAY: begin
          key_index_next = key_index + 2'd1;
          if (remaining != 32'd0) begin
            remaining_next = remaining - 32'd1;
          end
          res_valid   = 1'b1;
          res.kind    = RK_PAYLOAD;
          res.length  = acc[31:0];
          res.payload = held_mask ? (data_byte ^ mask_key[key_index]) : data_byte;
          res.last    = (remaining_next == 32'd0);
        end
        default: begin
          held_fin_next    = data_byte[7];
          held_rsv_next    = data_byte[6:4];
          held_opcode_next = data_byte[3:0];
        end
      endcase

      // length fully known: check against the limit
      if (len_done) begin
        too_long = (acc_next[63:32] != 32'd0) || (acc_next[31:0] > max_len);
        if (too_long) begin
          error_latched_next = 1'b1;
          res_valid          = 1'b1;
          res.kind           = RK_LEN_ERR;
          res.length         = (acc_next[63:32] != 32'd0) ? LEN_SATURATED : acc_next[31:0];
          res.last           = 1'b1;
        end else begin
          fbc_next = 3'd0;
          hdr_done = !held_mask_next;
        end
      end

      // header complete
      if (hdr_done) begin
        remaining_next = acc_next[31:0];
        key_index_next = 2'd0;
        res_valid      = 1'b1;
        res.kind       = RK_HEADER;
        res.length     = acc_next[31:0];
        res.last       = (acc_next[31:0] == 32'd0);
      end

      res.fin    = held_fin_next;
      res.rsv    = held_rsv_next;
      res.opcode = held_opcode_next;
      res.masked = held_mask_next;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      case (phase)
        P_HDR1: phase_next = P_EXT;
        P_EXT:  phase_next = P_EXT;
        P_KEY:  phase_next = P_KEY;
        P_PAY:  phase_next = (remaining_next == 32'd0) ? P_HDR0 : P_PAY;
        default: phase_next = P_HDR1;
      endcase
      if (len_done && !too_long && held_mask_next) begin
        phase_next = P_KEY;
      end
      if (hdr_done) begin
        phase_next = (acc_next[31:0] == 32'd0) ? P_HDR0 : P_PAY;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= P_HDR0;
      fbc           <= 3'd0;
      acc           <= 64'd0;
      remaining     <= 32'd0;
      key_index     <= 2'd0;
      held_fin      <= 1'b0;
      held_rsv      <= 3'd0;
      held_opcode   <= 4'd0;
      held_mask     <= 1'b0;
      length_code   <= 7'd0;
      error_latched <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        mask_key[i] <= 8'd0;
      end
    end else begin
      phase         <= phase_next;
      fbc           <= fbc_next;
      acc           <= acc_next;
      remaining     <= remaining_next;
      key_index     <= key_index_next;
      held_fin      <= held_fin_next;
      held_rsv      <= held_rsv_next;
      held_opcode   <= held_opcode_next;
      held_mask     <= held_mask_next;
      length_code   <= length_code_next;
      error_latched <= error_latched_next;
      if (key_wr) begin
        mask_key[key_wr_idx] <= data_byte;
      end
    end
  end

  // Output buffer: result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_reg <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  assign result_kind   = out_reg.kind;
  assign fin_flag      = out_reg.fin;
  assign rsv_bits      = out_reg.rsv;
  assign frame_opcode  = out_reg.opcode;
  assign masked_flag   = out_reg.masked;
  assign frame_length  = out_reg.length;
  assign payload_byte  = out_reg.payload;
  assign last_of_frame = out_reg.last;

  // Checks
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("length error latch cleared without reset");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == P_PAY) |-> (remaining != 32'd0))
    else $error("payload phase with no bytes remaining");

  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    (error_latched && !out_valid) |=> !out_valid)
    else $error("result produced after length error");

endmodule

[bench/websocket_frame_deframer_tb.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Self-checking bench for the WebSocket receive-side frame deframer.
// ----------------------------------------------------------------------------
// Bytes go in over a valid/ready channel. Each accepted byte runs through a
// frame decoder kept in the bench. The decoder queues the header, payload and
// length-error results that the byte should produce. A monitor compares every
// result transfer field by field against the oldest queued result. Both sides
// insert random idle cycles. The limit register is reprogrammed over APB
// between traffic phases. A length error latches for good, so the error
// test runs last.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
  import wsdf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 230;
  localparam int PRINT_CAP     = 40;

  // Ways a payload length can be encoded in the header
  typedef enum int {
    ENC_SHORT,  // 7-bit length code
    ENC_EXT16,  // code 126 plus 16-bit length
    ENC_EXT64   // code 127 plus 64-bit length
  } len_enc_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic        fin_flag;
  logic [2:0]  rsv_bits;
  logic [3:0]  frame_opcode;
  logic        masked_flag;
  logic [31:0] frame_length;
  logic [7:0]  payload_byte;
  logic        last_of_frame;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  websocket_frame_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .fin_flag      (fin_flag),
    .rsv_bits      (rsv_bits),
    .frame_opcode  (frame_opcode),
    .masked_flag   (masked_flag),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int          fail_count  = 0;
  int          cycle_count = 0;
  int          bytes_sent  = 0;
  bit          steady_send = 1'b0;
  bit          ready_steady = 1'b0;
  int unsigned ready_hold  = 0;

  // Bench copy of the decoder state and the limit register
  phase_t      parse_st      = P_HDR0;
  logic [2:0]  ext_count     = '0;
  logic [63:0] len_sum       = '0;
  logic [31:0] bytes_left    = '0;
  logic [7:0]  mask_key [4]  = '{default: '0};
  logic [1:0]  key_pos       = '0;
  logic        cur_fin       = 1'b0;
  logic [2:0]  cur_rsv       = '0;
  logic [3:0]  cur_opcode    = '0;
  logic        cur_masked    = 1'b0;
  logic [6:0]  len_code_seen = '0;
  bit          stream_dead   = 1'b0;
  logic [31:0] payload_limit = MAX_LEN_RESET;

  // Decoded results still waiting for their transfer, oldest first
  result_t decoded_results [$];

  // ------------------------------------------------------------------------
  // Frame decoder
  // ------------------------------------------------------------------------
  function automatic void queue_result(input kind_t kind, input logic [31:0] len,
                                       input logic [7:0] pb, input logic last);
    result_t r;
    r.kind    = kind;
    r.fin     = cur_fin;
    r.rsv     = cur_rsv;
    r.opcode  = cur_opcode;
    r.masked  = cur_masked;
    r.length  = len;
    r.payload = pb;
    r.last    = last;
    decoded_results.push_back(r);
  endfunction

  // Header done: announce it, then payload or next frame
  function automatic void close_header();
    bytes_left = len_sum[31:0];
    key_pos    = '0;
    queue_result(RK_HEADER, len_sum[31:0], 8'h00, bytes_left == 0);
    parse_st = (bytes_left == 0) ? P_HDR0 : P_PAY;
  endfunction

  // Length fully known: limit check comes before the masking key
  function automatic void check_length();
    if (len_sum > {32'h0, payload_limit}) begin
      stream_dead = 1'b1;
      queue_result(RK_LEN_ERR, (len_sum[63:32] != 0) ? LEN_SATURATED : len_sum[31:0],
                   8'h00, 1'b1);
      return;
    end
    ext_count = '0;
    if (cur_masked) parse_st = P_KEY;
    else close_header();
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] plain;
    if (stream_dead) return;
    case (parse_st)
      P_HDR1: begin
        cur_masked    = b[7];
        len_code_seen = b[6:0];
        ext_count     = '0;
        len_sum       = '0;
        if (len_code_seen < LEN_CODE_16) begin
          len_sum = {57'h0, len_code_seen};
          check_length();
        end else begin
          parse_st = P_EXT;
        end
      end
      P_EXT: begin
        len_sum   = {len_sum[55:0], b};
        ext_count = ext_count + 3'd1;
        if ((len_code_seen == LEN_CODE_16 && ext_count == EXT16_BYTES) ||
            (len_code_seen == LEN_CODE_64 && ext_count == EXT64_WRAP))
          check_length();
      end
      P_KEY: begin
        mask_key[ext_count[1:0]] = b;
        ext_count = ext_count + 3'd1;
        if (ext_count >= KEY_BYTES) begin
          ext_count = '0;
          close_header();
        end
      end
      P_PAY: begin
        plain   = cur_masked ? (b ^ mask_key[key_pos]) : b;
        key_pos = key_pos + 2'd1;
        if (bytes_left != 0) bytes_left = bytes_left - 32'd1;
        queue_result(RK_PAYLOAD, len_sum[31:0], plain, bytes_left == 0);
        if (bytes_left == 0) parse_st = P_HDR0;
      end
      default: begin
        cur_fin    = b[7];
        cur_rsv    = b[6:4];
        cur_opcode = b[3:0];
        parse_st   = P_HDR1;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (decoded_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with nothing expected", result_kind));
      return;
    end
    want = decoded_results.pop_front();
    check_field("result_kind", result_kind, want.kind);
    check_field("fin_flag", fin_flag, want.fin);
    check_field("rsv_bits", rsv_bits, want.rsv);
    check_field("frame_opcode", frame_opcode, want.opcode);
    check_field("masked_flag", masked_flag, want.masked);
    check_field("frame_length", frame_length, want.length);
    check_field("payload_byte", payload_byte, want.payload);
    check_field("last_of_frame", last_of_frame, want.last);
  endtask

  // Result side: check each transfer, then draw the stall before the next one
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        check_result();
        if ($urandom_range(0, 63) == 0) ready_steady = !ready_steady;
        ready_hold = ready_steady ? 0 : $urandom_range(0, 18);
      end
      if (ready_hold != 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Byte sender and frame builder
  // ------------------------------------------------------------------------
  // Valid stays high across back-to-back transfers; it drops only for a gap or when results are drained.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = steady_send ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    deframe_byte(value);
    bytes_sent++;
  endtask

  function automatic len_enc_t choose_encoding(input logic [63:0] len);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (len > 64'd65535) return ENC_EXT64;
    if (len >= 64'd126) return (roll < 5) ? ENC_EXT16 : ENC_EXT64;
    if (roll < 7) return ENC_SHORT;
    return (roll < 9) ? ENC_EXT16 : ENC_EXT64;
  endfunction

  // Random header byte 0, then length, optional key and body_bytes random bytes
  task automatic send_frame(input logic [63:0] len, input len_enc_t enc,
                            input bit keyed, input int unsigned body_bytes);
    int i;
    steady_send = ($urandom_range(0, 2) == 0);
    send_byte(8'($urandom_range(0, 255)));
    case (enc)
      ENC_SHORT: send_byte({keyed, len[6:0]});
      ENC_EXT16: begin
        send_byte({keyed, LEN_CODE_16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({keyed, LEN_CODE_64});
        for (i = 7; i >= 0; i--) send_byte(len[i*8 +: 8]);
      end
    endcase
    if (keyed) repeat (4) send_byte(8'($urandom_range(0, 255)));
    repeat (body_bytes) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stop sending and wait for every queued result, then let the bench settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // APB access
  // ------------------------------------------------------------------------
  task automatic apb_access(input bit write_en, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= ADDR_MAX_LEN;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_limit(input logic [31:0] value);
    logic [31:0] readback;
    apb_access(1'b1, value, readback);
    payload_limit = value;
    apb_access(1'b0, '0, readback);
    if (readback !== value)
      report_mismatch($sformatf("max_payload_length read %0h, wrote %0h", readback, value));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_register_readback();
    logic [31:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback !== MAX_LEN_RESET)
      report_mismatch($sformatf("max_payload_length reset value %0h", readback));
    program_limit(32'h0000_0000);
    program_limit(32'hA5A5_5A5A);
    program_limit(32'h5A5A_A5A5);
    program_limit(MAX_LEN_RESET);
  endtask

  // Empty frame, masked frame with all header bits set, 16- and 64-bit lengths
  task automatic test_directed_frames();
    logic [7:0] stream [27];
    stream = '{8'h00, 8'h00,
               8'hFF, 8'h83, 8'h12, 8'hED, 8'h80, 8'h7F, 8'hFF, 8'h00, 8'hA5,
               8'h82, {1'b0, LEN_CODE_16}, 8'h00, 8'h01, 8'h5A,
               8'h80, {1'b0, LEN_CODE_64}, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h01, 8'hC3};
    steady_send = 1'b0;
    foreach (stream[i]) send_byte(stream[i]);
    drain_results();
  endtask

  // Well-formed frames with random content over several limit settings
  task automatic test_random_traffic();
    int phase;
    int start;
    int target;
    int unsigned cap;
    logic [31:0] len;
    for (phase = 0; phase < 7; phase++) begin
      drain_results();
      target = PHASE_ITEMS;
      case (phase)
        1: program_limit($urandom_range(1, 40));
        2: begin
          program_limit(32'h0000_0000);
          target = 60;
        end
        3: program_limit($urandom);
        4: program_limit(MAX_LEN_RESET);
        5: program_limit($urandom_range(1, 12));
        6: program_limit({8'($urandom_range(1, 255)), 24'h0});
        default: ;
      endcase
      start = bytes_sent;
      while (bytes_sent - start < target) begin
        cap = (payload_limit < 40) ? payload_limit : 40;
        if ($urandom_range(0, 24) == 0) cap = (payload_limit < 300) ? payload_limit : 300;
        len = $urandom_range(0, cap);
        // frames right at the limit
        if (payload_limit <= 40 && $urandom_range(0, 5) == 0) len = payload_limit;
        send_frame({32'h0, len}, choose_encoding({32'h0, len}),
                   1'($urandom_range(0, 1)), len);
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end
    drain_results();
  endtask

  // Over-limit length: one error result, then the stream stays dead
  task automatic test_length_error();
    logic [31:0] lim;
    logic [63:0] bad_len;
    len_enc_t    enc;
    drain_results();
    lim = $urandom_range(1, 40);
    program_limit(lim);
    send_frame({32'h0, lim}, choose_encoding({32'h0, lim}), 1'b1, lim);
    send_frame(64'd0, ENC_SHORT, 1'b0, 0);
    case ($urandom_range(0, 2))
      0: begin
        bad_len = {32'h0, $urandom_range(lim + 1, 125)};
        enc     = ENC_SHORT;
      end
      1: begin
        bad_len = {32'h0, $urandom_range(lim + 1, 65535)};
        enc     = ENC_EXT16;
      end
      default: begin
        // above 32 bits, reported saturated
        bad_len[63:32] = $urandom_range(1, 32'hFFFF_FFFF);
        bad_len[31:0]  = $urandom;
        enc            = ENC_EXT64;
      end
    endcase
    // key and trailing bytes are dropped
    send_frame(bad_len, enc, 1'b1, 24);
    drain_results();
    // a register write leaves the error in place
    program_limit(MAX_LEN_RESET);
    send_frame(64'd0, ENC_SHORT, 1'b0, 0);
    send_frame(64'd5, ENC_SHORT, 1'b1, 5);
    drain_results();
  endtask

  initial begin : run_tests
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_register_readback();
    test_directed_frames();
    test_random_traffic();
    test_length_error();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[websocket_frame_deframer.f]
hw/rtl/wsdf_pkg.sv
hw/rtl/websocket_frame_deframer.sv
bench/websocket_frame_deframer_tb.sv
